[hdl/rrsc_pkg.sv]
// Shared types, sizes and codes for the resource request safety check.
package rrsc_pkg;

    localparam int MAX_PROCESSES = 8;
    localparam int MAX_RESOURCES = 4;
    localparam int COUNT_WIDTH   = 16;

    // Index and count widths derived from the sizes
    localparam int PI_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RI_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PC_W   = $clog2(MAX_PROCESSES + 1);
    localparam int RC_W   = $clog2(MAX_RESOURCES + 1);
    localparam int WORK_W = COUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

    // Input commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_MAX   = 2'd1;
    localparam logic [1:0] CMD_AVAIL = 2'd2;
    localparam logic [1:0] CMD_REQ   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_EXCEEDS = 2'd1;
    localparam logic [1:0] ST_NO_AVAIL = 2'd2;
    localparam logic [1:0] ST_UNSAFE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_PROC = 2'd0;
    localparam logic [1:0] CFG_NUM_RES  = 2'd1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [WORK_W-1:0]      work_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  process_id;
        logic [1:0]  resource_id;
        logic [15:0] amount;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] process_id_out;
        logic       last_out;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       check_step;
        logic       apply;
        logic       sweep_step;
        logic       rollback;
        logic       out_load;
        logic       out_seq;
        logic       out_last;
        logic [1:0] out_status;
        logic       clear_req;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_ok;
        logic pid_bad;
        logic j_last;
        logic need_fail;
        logic avail_fail;
        logic sweep_end;
        logic sweep_cont;
        logic all_done;
        logic k_last;
        logic out_free;
    } stat_t;

endpackage

[hdl/rrsc_ctrl.sv]
// Sequencer for loads, request checks, safety sweep and result transfers.
module rrsc_ctrl
    import rrsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     in_stall,
    input  stat_t    st,
    output cmd_t     cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_APPLY    = 3'd3;
    localparam logic [2:0] S_SWEEP    = 3'd4;
    localparam logic [2:0] S_ROLLBACK = 3'd5;
    localparam logic [2:0] S_EMIT_ONE = 3'd6;
    localparam logic [2:0] S_EMIT_SEQ = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       in_fire;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.accept = 1'b1;
                    if (st.item_ok && in_item.command == CMD_REQ && in_item.last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (st.pid_bad)
                begin
                    code_next  = ST_EXCEEDS;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    cmd.check_step = 1'b1;
                    if (st.j_last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (st.need_fail)
                begin
                    code_next  = ST_EXCEEDS;
                    state_next = S_EMIT_ONE;
                end
                else if (st.avail_fail)
                begin
                    code_next  = ST_NO_AVAIL;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_end && !st.sweep_cont)
                begin
                    state_next = st.all_done ? S_EMIT_SEQ : S_ROLLBACK;
                end
            end
            S_ROLLBACK:
            begin
                cmd.rollback = 1'b1;
                code_next    = ST_UNSAFE;
                state_next   = S_EMIT_ONE;
            end
            S_EMIT_ONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = code_reg;
                    cmd.out_last   = 1'b1;
                    cmd.clear_req  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_SEQ:
            begin
                if (st.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_seq    = 1'b1;
                    cmd.out_status = ST_GRANTED;
                    cmd.out_last   = st.k_last;
                    if (st.k_last)
                    begin
                        cmd.clear_req = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_GRANTED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

[hdl/rrsc_datapath.sv]
// Matrices, work vector, index counters and result register.
module rrsc_datapath
    import rrsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output stat_t     st,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    count_t alloc_reg [MAX_PROCESSES][MAX_RESOURCES];
    count_t maxc_reg  [MAX_PROCESSES][MAX_RESOURCES];
    count_t avail_reg [MAX_RESOURCES];
    count_t req_reg   [MAX_RESOURCES];
    work_t  work_reg  [MAX_RESOURCES];
    logic [PI_W-1:0] seq_reg [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] fin_reg;

    logic [3:0]      num_proc_reg;
    logic [2:0]      num_res_reg;
    logic [2:0]      pid_raw_reg;
    logic [PI_W-1:0] pid_reg;
    logic [RI_W-1:0] j_reg;
    logic [PI_W-1:0] i_reg;
    logic [PI_W-1:0] k_reg;
    logic [PC_W-1:0] done_reg;
    logic            prog_reg;
    logic            need_fail_reg;
    logic            avail_fail_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;

    logic [PC_W-1:0] np;
    logic [RC_W-1:0] nr;
    logic [PI_W-1:0] in_p;
    logic [RI_W-1:0] in_r;
    logic            i_last;
    count_t          need_pj;
    count_t          need_ij;
    logic            fail;
    logic            grant;
    logic            proc_end;
    logic            prog_new;
    logic [PC_W-1:0] done_new;

    // Saturate the configured sizes
    assign np = (num_proc_reg == 4'd0) ? PC_W'(1) :
                (32'(num_proc_reg) > MAX_PROCESSES) ? PC_W'(MAX_PROCESSES) :
                PC_W'(num_proc_reg);
    assign nr = (num_res_reg == 3'd0) ? RC_W'(1) :
                (32'(num_res_reg) > MAX_RESOURCES) ? RC_W'(MAX_RESOURCES) :
                RC_W'(num_res_reg);

    assign in_p = PI_W'(in_item.process_id);
    assign in_r = RI_W'(in_item.resource_id);

    // Need of the requester and of the swept process at element j
    assign need_pj = (maxc_reg[pid_reg][j_reg] > alloc_reg[pid_reg][j_reg]) ?
                     maxc_reg[pid_reg][j_reg] - alloc_reg[pid_reg][j_reg] : '0;
    assign need_ij = (maxc_reg[i_reg][j_reg] > alloc_reg[i_reg][j_reg]) ?
                     maxc_reg[i_reg][j_reg] - alloc_reg[i_reg][j_reg] : '0;

    // Sweep step decision
    assign i_last   = (32'(i_reg) == 32'(np) - 1);
    assign fail     = fin_reg[i_reg] || (WORK_W'(need_ij) > work_reg[j_reg]);
    assign proc_end = fail || st.j_last;
    assign grant    = !fail && st.j_last;
    assign prog_new = prog_reg || grant;
    assign done_new = done_reg + PC_W'(grant);

    always_comb
    begin
        st.item_ok    = (32'(in_item.process_id) < MAX_PROCESSES) &&
                        (32'(in_item.resource_id) < MAX_RESOURCES);
        st.pid_bad    = (32'(pid_raw_reg) >= 32'(np));
        st.j_last     = (32'(j_reg) == 32'(nr) - 1);
        st.need_fail  = need_fail_reg;
        st.avail_fail = avail_fail_reg;
        st.sweep_end  = i_last && proc_end;
        st.sweep_cont = prog_new && (done_new < np);
        st.all_done   = (done_new == np);
        st.k_last     = (32'(k_reg) == 32'(np) - 1);
        st.out_free   = !out_valid_reg || !out_stall;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_proc_reg <= 4'd8;
            num_res_reg  <= 3'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_PROC: num_proc_reg <= cfg_data;
                CFG_NUM_RES:  num_res_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // Allocation, claims, available and request buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_PROCESSES; p++)
            begin
                for (int r = 0; r < MAX_RESOURCES; r++)
                begin
                    alloc_reg[p][r] <= '0;
                    maxc_reg[p][r]  <= '0;
                end
            end
            for (int r = 0; r < MAX_RESOURCES; r++)
            begin
                avail_reg[r] <= '0;
                req_reg[r]   <= '0;
            end
        end
        else
        begin
            if (cmd.accept && st.item_ok)
            begin
                case (in_item.command)
                    CMD_ALLOC: alloc_reg[in_p][in_r] <= COUNT_WIDTH'(in_item.amount);
                    CMD_MAX:   maxc_reg[in_p][in_r]  <= COUNT_WIDTH'(in_item.amount);
                    CMD_AVAIL: avail_reg[in_r]       <= COUNT_WIDTH'(in_item.amount);
                    default:   req_reg[in_r]         <= COUNT_WIDTH'(in_item.amount);
                endcase
            end
            for (int r = 0; r < MAX_RESOURCES; r++)
            begin
                if (r < 32'(nr))
                begin
                    if (cmd.apply)
                    begin
                        avail_reg[r]          <= avail_reg[r] - req_reg[r];
                        alloc_reg[pid_reg][r] <= alloc_reg[pid_reg][r] + req_reg[r];
                    end
                    if (cmd.rollback)
                    begin
                        avail_reg[r]          <= avail_reg[r] + req_reg[r];
                        alloc_reg[pid_reg][r] <= alloc_reg[pid_reg][r] - req_reg[r];
                    end
                end
                if (cmd.clear_req)
                begin
                    req_reg[r] <= '0;
                end
            end
        end
    end

    // Work vector and safe sequence
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < MAX_RESOURCES; r++)
        begin
            if (cmd.apply)
            begin
                work_reg[r] <= (r < 32'(nr)) ? WORK_W'(avail_reg[r] - req_reg[r]) : '0;
            end
            else if (cmd.sweep_step && grant && r < 32'(nr))
            begin
                work_reg[r] <= work_reg[r] + WORK_W'(alloc_reg[i_reg][r]);
            end
        end
        if (cmd.sweep_step && grant)
        begin
            seq_reg[done_reg[PI_W-1:0]] <= i_reg;
        end
        if (cmd.accept)
        begin
            pid_raw_reg <= in_item.process_id;
            pid_reg     <= in_p;
        end
    end

    // Counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            done_reg       <= '0;
            prog_reg       <= 1'b0;
            fin_reg        <= '0;
            need_fail_reg  <= 1'b0;
            avail_fail_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                j_reg          <= '0;
                need_fail_reg  <= 1'b0;
                avail_fail_reg <= 1'b0;
            end
            if (cmd.check_step)
            begin
                if (req_reg[j_reg] > need_pj)
                begin
                    need_fail_reg <= 1'b1;
                end
                if (req_reg[j_reg] > avail_reg[j_reg])
                begin
                    avail_fail_reg <= 1'b1;
                end
                j_reg <= st.j_last ? '0 : j_reg + 1'b1;
            end
            if (cmd.apply)
            begin
                j_reg    <= '0;
                i_reg    <= '0;
                k_reg    <= '0;
                done_reg <= '0;
                prog_reg <= 1'b0;
                fin_reg  <= '0;
            end
            if (cmd.sweep_step)
            begin
                if (grant)
                begin
                    fin_reg[i_reg] <= 1'b1;
                end
                done_reg <= done_new;
                if (proc_end)
                begin
                    j_reg    <= '0;
                    i_reg    <= i_last ? '0 : i_reg + 1'b1;
                    prog_reg <= i_last ? 1'b0 : prog_new;
                end
                else
                begin
                    j_reg    <= j_reg + 1'b1;
                    prog_reg <= prog_new;
                end
            end
            if (cmd.out_load && cmd.out_seq)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Result register: load on a free slot, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status         <= cmd.out_status;
            out_reg.process_id_out <= cmd.out_seq ? 3'(seq_reg[k_reg]) : pid_raw_reg;
            out_reg.last_out       <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[hdl/resource_request_safety_check_core.sv]
// Top level of the resource request safety check allocator.
// Loads and non-last request elements are taken straight from the idle state; a closing request
// element runs the check over nr elements (skipped if the process is not in use), then decide; a passing
// request adds apply, the sweep (one matrix element compared per cycle) and rollback if unsafe.
// Results leave one per cycle from the output register while rsp_stall is low.
// Reset (rst_n, asynchronous, active low) clears matrices, available vector and control.
module resource_request_safety_check_core
    import rrsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  in_item_t   cmd_item,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output out_item_t  rsp_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    assign cfg_ready = 1'b1;

    rrsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_valid),
        .in_item  (cmd_item),
        .in_stall (cmd_stall),
        .st       (st),
        .cmd      (cmd)
    );

    rrsc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (cmd_item),
        .cmd       (cmd),
        .st        (st),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_item  (rsp_item)
    );

    // Never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || !rsp_stall))
        else $error("result register overwritten");

    // No result is loaded while an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |-> !cmd.out_load)
        else $error("result loaded during item transfer");

    // A tentative grant only follows a clean check
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!st.need_fail && !st.avail_fail))
        else $error("request applied after failed check");

endmodule
